// ===== hw/rtl/bbie_pkg.sv =====
`timescale 1ns / 1ps

package bbie_pkg;

   // Operation codes carried by each request word
   typedef enum logic [1:0] {
      OP_SET    = 2'd0,
      OP_INSERT = 2'd1,
      OP_ERASE  = 2'd2,
      OP_GET    = 2'd3
   } op_type;

   // Request word
   typedef struct packed {
      op_type      op;
      logic [7:0]  index;
      logic [7:0]  value;
      logic [8:0]  length;
      logic [1:0]  width_code;
      logic        big_endian;
   } req_payload_type;

   // Response word
   typedef struct packed {
      logic        ok;
      logic [63:0] read_data;
      logic [8:0]  fill_count;
   } rsp_payload_type;

endpackage

// ===== hw/rtl/bbie_if.sv =====
`timescale 1ns / 1ps

// Request channel
interface bbie_req_if;
   import bbie_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// Response channel
interface bbie_rsp_if;
   import bbie_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/bbie_store.sv =====
`timescale 1ns / 1ps

// Byte store: one write port, one read port, registered read data
module bbie_store #(
   parameter int DEPTH = 256,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] store_ff [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/byte_buffer_insert_erase_get.sv =====
`timescale 1ns / 1ps

// Channel    Dir  Word                                              Handshake
// req_chan   in   op, index, value, length, width_code, big_endian  valid/ready
// rsp_chan   out  ok, read_data, fill_count                         valid/ready
//
// One word at a time. Bytes moved per item: set none, get nbytes, insert
// (count - pos), erase (count - index - n) when n is non-zero, up to about
// DEPTH. The moves go one byte per cycle through the store's single read and
// single write port.
// Synchronous reset empties the buffer (count zero); no clearing pass.
// The response register lets a new request in while the last word waits;
// completion holds in the final step until that register is free.
module byte_buffer_insert_erase_get #(
   parameter int DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   bbie_req_if.sink    req_chan,
   bbie_rsp_if.source  rsp_chan
);
   import bbie_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int EW = ((CW > 9) ? CW : 9) + 1;
   localparam logic [EW-1:0] DEPTH_E = EW'(DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MOVE,
      ST_FINAL
   } state_type;

   // Registers
   state_type      state_ff, state_in;
   op_type         op_ff, op_in;
   logic [7:0]     idx_ff, idx_in;
   logic [7:0]     value_ff, value_in;
   logic [8:0]     len_ff, len_in;
   logic [1:0]     wcode_ff, wcode_in;
   logic           big_ff, big_in;
   logic           ok_ff, ok_in;
   logic           fin_wr_ff, fin_wr_in;
   logic [AW-1:0]  fin_addr_ff, fin_addr_in;
   logic [CW-1:0]  new_cnt_ff, new_cnt_in;
   logic [CW-1:0]  left_ff, left_in;
   logic [AW-1:0]  src_ff, src_in;
   logic [AW-1:0]  dst_ff, dst_in;
   logic           up_ff, up_in;
   logic           pend_ff, pend_in;
   logic [AW-1:0]  pend_dst_ff, pend_dst_in;
   logic [63:0]    acc_ff, acc_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_ok_ff, rsp_ok_in;
   logic [63:0]    rsp_data_ff, rsp_data_in;
   logic [8:0]     rsp_fill_ff, rsp_fill_in;

   // Store port
   logic           wr_en;
   logic [AW-1:0]  wr_addr;
   logic [7:0]     wr_data;
   logic           rd_en;
   logic [AW-1:0]  rd_addr;
   logic [7:0]     rd_data;

   // Decode arithmetic
   logic [EW-1:0]  cnt_e, idx_e, len_e, nb_e, pos_e, tail_e, n_e, moves_e;

   bbie_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Operand terms for the decode step
   always_comb begin
      cnt_e  = EW'(count_ff);
      idx_e  = EW'(idx_ff);
      len_e  = EW'(len_ff);
      nb_e   = EW'(1) << wcode_ff;
      pos_e  = (idx_e > cnt_e) ? cnt_e : idx_e;
      tail_e = cnt_e - idx_e;
      n_e    = (len_e < tail_e) ? len_e : tail_e;
   end

   // Next-state logic
   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      idx_in      = idx_ff;
      value_in    = value_ff;
      len_in      = len_ff;
      wcode_in    = wcode_ff;
      big_in      = big_ff;
      ok_in       = ok_ff;
      fin_wr_in   = fin_wr_ff;
      fin_addr_in = fin_addr_ff;
      new_cnt_in  = new_cnt_ff;
      left_in     = left_ff;
      src_in      = src_ff;
      dst_in      = dst_ff;
      up_in       = up_ff;
      pend_in     = pend_ff;
      pend_dst_in = pend_dst_ff;
      acc_in      = acc_ff;
      count_in    = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in   = rsp_ok_ff;
      rsp_data_in = rsp_data_ff;
      rsp_fill_in = rsp_fill_ff;
      moves_e     = '0;

      wr_en   = 1'b0;
      wr_addr = pend_dst_ff;
      wr_data = rd_data;
      rd_en   = 1'b0;
      rd_addr = src_ff;

      // response word taken
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               op_in    = req_chan.data.op;
               idx_in   = req_chan.data.index;
               value_in = req_chan.data.value;
               len_in   = req_chan.data.length;
               wcode_in = req_chan.data.width_code;
               big_in   = req_chan.data.big_endian;
               state_in = ST_DECODE;
            end
         end

         // range checks, move count and walk setup
         ST_DECODE: begin
            ok_in       = 1'b0;
            fin_wr_in   = 1'b0;
            fin_addr_in = AW'(idx_e);
            new_cnt_in  = count_ff;
            src_in      = AW'(idx_e);
            dst_in      = AW'(idx_e);
            up_in       = 1'b1;
            acc_in      = '0;
            pend_in     = 1'b0;
            case (op_ff)
               OP_SET: begin
                  ok_in     = idx_e < cnt_e;
                  fin_wr_in = idx_e < cnt_e;
               end
               OP_INSERT: begin
                  ok_in       = cnt_e < DEPTH_E;
                  fin_wr_in   = cnt_e < DEPTH_E;
                  fin_addr_in = AW'(pos_e);
                  src_in      = AW'(cnt_e - EW'(1));
                  dst_in      = AW'(cnt_e);
                  up_in       = 1'b0;
                  if (cnt_e < DEPTH_E) begin
                     moves_e    = cnt_e - pos_e;
                     new_cnt_in = count_ff + CW'(1);
                  end
               end
               OP_ERASE: begin
                  ok_in  = idx_e < cnt_e;
                  src_in = AW'(idx_e + n_e);
                  if (idx_e < cnt_e) begin
                     new_cnt_in = CW'(cnt_e - n_e);
                     if (n_e != '0) begin
                        moves_e = tail_e - n_e;
                     end
                  end
               end
               OP_GET: begin
                  ok_in  = (idx_e + nb_e) <= cnt_e;
                  up_in  = big_ff;
                  src_in = big_ff ? AW'(idx_e) : AW'(idx_e + nb_e - EW'(1));
                  if ((idx_e + nb_e) <= cnt_e) begin
                     moves_e = nb_e;
                  end
               end
               default: begin
                  ok_in = 1'b0;
               end
            endcase
            left_in  = CW'(moves_e);
            state_in = ST_MOVE;
         end

         // one read issued and one write retired (for get, one byte shifted into the accumulator) per cycle
         ST_MOVE: begin
            if (left_ff != '0) begin
               rd_en       = 1'b1;
               rd_addr     = src_ff;
               src_in      = up_ff ? src_ff + AW'(1) : src_ff - AW'(1);
               dst_in      = up_ff ? dst_ff + AW'(1) : dst_ff - AW'(1);
               left_in     = left_ff - CW'(1);
               pend_in     = 1'b1;
               pend_dst_in = dst_ff;
            end else begin
               pend_in  = 1'b0;
               state_in = ST_FINAL;
            end
            if (pend_ff) begin
               if (op_ff == OP_GET) begin
                  acc_in = {acc_ff[55:0], rd_data};
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = pend_dst_ff;
                  wr_data = rd_data;
               end
            end
         end

         // last byte write, count update and response
         ST_FINAL: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               wr_en        = fin_wr_ff;
               wr_addr      = fin_addr_ff;
               wr_data      = value_ff;
               count_in     = new_cnt_ff;
               rsp_valid_in = 1'b1;
               rsp_ok_in    = ok_ff;
               rsp_data_in  = acc_ff;
               rsp_fill_in  = 9'(new_cnt_ff);
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      idx_ff      <= idx_in;
      value_ff    <= value_in;
      len_ff      <= len_in;
      wcode_ff    <= wcode_in;
      big_ff      <= big_in;
      ok_ff       <= ok_in;
      fin_wr_ff   <= fin_wr_in;
      fin_addr_ff <= fin_addr_in;
      new_cnt_ff  <= new_cnt_in;
      left_ff     <= left_in;
      src_ff      <= src_in;
      dst_ff      <= dst_in;
      up_ff       <= up_in;
      pend_dst_ff <= pend_dst_in;
      acc_ff      <= acc_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_data_ff <= rsp_data_in;
      rsp_fill_ff <= rsp_fill_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_chan.ready           = (state_ff == ST_IDLE);
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.data.ok         = rsp_ok_ff;
   assign rsp_chan.data.read_data  = rsp_data_ff;
   assign rsp_chan.data.fill_count = rsp_fill_ff;

endmodule

// ===== tb/tb_byte_buffer_insert_erase_get.sv =====
`timescale 1ns / 1ps

module tb_byte_buffer_insert_erase_get;
   import bbie_pkg::*;

   localparam int DEPTH      = 256;
   localparam int WATCH_LIMIT = 3000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bbie_req_if req_bus ();
   bbie_rsp_if rsp_bus ();

   byte_buffer_insert_erase_get #(
      .DEPTH(DEPTH)
   ) uut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus)
   );

   always #4 clock = ~clock;

   // Shadow copy of the buffer contents and fill count
   logic [7:0]      buffer_bytes [DEPTH];
   int unsigned     buffer_fill;
   int unsigned     peak_fill;
   rsp_payload_type pending_rsp [$];

   int unsigned err_count;
   int unsigned ops_seen [4];
   int unsigned ok_seen;
   int unsigned idle_cycles;
   bit          idle_on;
   int unsigned stall_left;

   // Apply one accepted word to the shadow buffer, return the response it should get
   function automatic rsp_payload_type apply_to_buffer(req_payload_type w);
      rsp_payload_type r;
      int unsigned     idx, n, nb, k, pos;
      logic [63:0]     acc;
      logic            good;
      idx  = w.index;
      acc  = '0;
      good = 1'b0;
      case (w.op)
         OP_SET: begin
            if (idx < buffer_fill) begin
               buffer_bytes[idx] = w.value;
               good = 1'b1;
            end
         end
         OP_INSERT: begin
            if (buffer_fill < DEPTH) begin
               if (idx > buffer_fill) idx = buffer_fill;
               for (k = buffer_fill; k > idx; k--) buffer_bytes[k] = buffer_bytes[k - 1];
               buffer_bytes[idx] = w.value;
               buffer_fill++;
               good = 1'b1;
            end
         end
         OP_ERASE: begin
            if (idx < buffer_fill) begin
               n = buffer_fill - idx;
               if (w.length < n) n = w.length;
               for (k = idx; k + n < buffer_fill; k++) buffer_bytes[k] = buffer_bytes[k + n];
               buffer_fill -= n;
               good = 1'b1;
            end
         end
         default: begin
            nb = 1 << w.width_code;
            if (idx + nb <= buffer_fill) begin
               for (k = 0; k < nb; k++) begin
                  pos = w.big_endian ? idx + k : idx + nb - 1 - k;
                  acc = {acc[55:0], buffer_bytes[pos]};
               end
               good = 1'b1;
            end
         end
      endcase
      ops_seen[w.op]++;
      if (good) ok_seen++;
      if (buffer_fill > peak_fill) peak_fill = buffer_fill;
      r.ok         = good;
      r.read_data  = good ? acc : 64'd0;
      r.fill_count = 9'(buffer_fill);
      return r;
   endfunction

   function automatic req_payload_type make_word(op_type op, int unsigned index,
                                                 int unsigned value, int unsigned length,
                                                 int unsigned wcode, bit big);
      req_payload_type w;
      w.op         = op;
      w.index      = 8'(index);
      w.value      = 8'(value);
      w.length     = 9'(length);
      w.width_code = 2'(wcode);
      w.big_endian = big;
      return w;
   endfunction

   // Random word steered so the fill count wanders around target
   function automatic req_payload_type next_random_word(int unsigned target);
      req_payload_type w;
      int unsigned     roll, nb, top, ins_cut, era_cut, set_cut;
      w.op         = OP_GET;
      w.index      = '0;
      w.value      = 8'($urandom_range(0, 255));
      w.length     = 9'($urandom_range(0, 4));
      w.width_code = 2'($urandom_range(0, 3));
      w.big_endian = 1'($urandom_range(0, 1));
      top     = (buffer_fill > 255) ? 255 : buffer_fill;
      ins_cut = (buffer_fill < target) ? 50 : 22;
      era_cut = ins_cut + ((buffer_fill > target) ? 30 : 10);
      set_cut = era_cut + 15;
      roll    = $urandom_range(0, 99);
      if (roll < 8) begin
         // noise: any field anywhere
         w.op     = op_type'(2'($urandom_range(0, 3)));
         w.index  = 8'($urandom_range(0, 255));
         w.length = 9'($urandom_range(0, 256));
      end else if (roll < ins_cut) begin
         w.op    = OP_INSERT;
         w.index = 8'($urandom_range(0, top));
      end else if (roll < era_cut) begin
         w.op    = OP_ERASE;
         w.index = buffer_fill ? 8'($urandom_range(0, buffer_fill - 1)) : 8'd0;
         if ($urandom_range(0, 9) == 0) w.length = 9'($urandom_range(0, 256));
      end else if (roll < set_cut) begin
         w.op    = OP_SET;
         w.index = buffer_fill ? 8'($urandom_range(0, buffer_fill - 1)) : 8'd0;
      end else begin
         nb      = 1 << w.width_code;
         w.index = (buffer_fill >= nb) ? 8'($urandom_range(0, buffer_fill - nb))
                                       : 8'($urandom_range(0, 7));
      end
      return w;
   endfunction

   // Send one request word; called and returns at a falling edge
   task automatic send_word(input req_payload_type w);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data  <= w;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_rsp.push_back(apply_to_buffer(w));
      @(negedge clock);
   endtask

   // Response side back-pressure in random bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 17) - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Response checker
   always @(posedge clock) begin
      rsp_payload_type exp_w;
      rsp_payload_type got_w;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got_w = rsp_bus.data;
         if (pending_rsp.size() == 0) begin
            $error("response word with none outstanding: ok=%0d data=%h fill=%0d",
                   got_w.ok, got_w.read_data, got_w.fill_count);
            err_count++;
         end else begin
            exp_w = pending_rsp.pop_front();
            if (got_w.ok !== exp_w.ok) begin
               $error("ok: expected %0d, got %0d", exp_w.ok, got_w.ok);
               err_count++;
            end
            if (got_w.read_data !== exp_w.read_data) begin
               $error("read_data: expected %h, got %h", exp_w.read_data, got_w.read_data);
               err_count++;
            end
            if (got_w.fill_count !== exp_w.fill_count) begin
               $error("fill_count: expected %0d, got %0d", exp_w.fill_count,
                      got_w.fill_count);
               err_count++;
            end
         end
      end
   end

   // Watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCH_LIMIT) begin
         $display("[byte_buffer_insert_erase_get] ERROR");
         $finish;
      end
   end

   // Operations on an empty buffer, then a lone append that is read back and erased
   task automatic test_empty_buffer();
      idle_on = 1'b0;
      send_word(make_word(OP_SET, 0, 8'hA5, 0, 0, 0));
      send_word(make_word(OP_ERASE, 0, 0, 1, 0, 0));
      send_word(make_word(OP_GET, 0, 0, 0, 0, 1));
      send_word(make_word(OP_INSERT, 200, 8'hFF, 0, 0, 0));
      send_word(make_word(OP_GET, 0, 0, 0, 0, 0));
      send_word(make_word(OP_ERASE, 0, 0, 1, 0, 0));
   endtask

   // Each operation with its edge cases on a short buffer
   task automatic test_basic_ops();
      idle_on = 1'b1;
      send_word(make_word(OP_INSERT, 0, 8'h5A, 0, 0, 0));
      send_word(make_word(OP_INSERT, 0, 8'h00, 0, 0, 0));
      send_word(make_word(OP_INSERT, 1, 8'hFF, 0, 0, 0));
      send_word(make_word(OP_INSERT, 255, 8'h81, 0, 0, 0));
      send_word(make_word(OP_SET, 3, 8'h7E, 0, 0, 0));
      send_word(make_word(OP_SET, 4, 8'h11, 0, 0, 0));
      send_word(make_word(OP_GET, 3, 0, 0, 0, 0));
      send_word(make_word(OP_GET, 0, 0, 0, 1, 1));
      send_word(make_word(OP_GET, 0, 0, 0, 2, 0));
      send_word(make_word(OP_GET, 1, 0, 0, 2, 1));
      send_word(make_word(OP_ERASE, 1, 0, 0, 0, 0));
      send_word(make_word(OP_ERASE, 1, 0, 256, 0, 0));
      send_word(make_word(OP_ERASE, 1, 0, 3, 0, 0));
      send_word(make_word(OP_ERASE, 0, 0, 1, 0, 0));
   endtask

   // Fill to capacity with random placement, then probe the full store and erase it down to empty
   task automatic test_full_buffer();
      int unsigned i;
      idle_on = 1'b1;
      for (i = 0; i < DEPTH; i++)
         send_word(make_word(OP_INSERT, $urandom_range(0, (i > 255) ? 255 : i),
                             $urandom_range(0, 255), 0, 0, 0));
      send_word(make_word(OP_INSERT, 0, 8'h3C, 0, 0, 0));
      send_word(make_word(OP_INSERT, 255, 8'h3C, 0, 0, 0));
      send_word(make_word(OP_GET, 248, 0, 0, 3, 1));
      send_word(make_word(OP_GET, 0, 0, 0, 3, 0));
      send_word(make_word(OP_GET, 255, 0, 0, 1, 1));
      send_word(make_word(OP_SET, 255, 8'h00, 0, 0, 0));
      send_word(make_word(OP_GET, 255, 0, 0, 0, 0));
      send_word(make_word(OP_ERASE, 128, 0, 256, 0, 0));
      send_word(make_word(OP_ERASE, 0, 0, 256, 0, 0));
   endtask

   task automatic test_random_traffic(int unsigned count, int unsigned target, bit idle);
      int unsigned i;
      idle_on = idle;
      for (i = 0; i < count; i++) send_word(next_random_word(target));
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.data  = '0;
      rsp_bus.ready = 1'b0;
      err_count     = 0;
      ok_seen       = 0;
      peak_fill     = 0;
      buffer_fill   = 0;
      stall_left    = 0;
      idle_cycles   = 0;
      idle_on       = 1'b0;
      ops_seen      = '{default: 0};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_buffer();
      test_basic_ops();
      test_full_buffer();
      test_random_traffic(200, 20, 1'b1);
      test_random_traffic(200, 235, 1'b1);
      test_random_traffic(100, 128, 1'b0);
      test_random_traffic(80, 64, 1'b1);
      test_random_traffic(140, 96, 1'b0);
      req_bus.valid <= 1'b0;

      // drain, then leave room for a stray late word
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DEPTH + 16) @(posedge clock);
      if (pending_rsp.size() != 0) begin
         $error("%0d responses never arrived", pending_rsp.size());
         err_count++;
      end

      $display("Words: %0d set, %0d insert, %0d erase, %0d get; %0d returned ok",
               ops_seen[OP_SET], ops_seen[OP_INSERT], ops_seen[OP_ERASE],
               ops_seen[OP_GET], ok_seen);
      $display("Peak fill %0d of %0d, with full-store, past-count and clipped-erase cases",
               peak_fill, DEPTH);
      if (err_count == 0) begin
         $display("[byte_buffer_insert_erase_get] OK");
      end else begin
         $display("[byte_buffer_insert_erase_get] ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/bbie_pkg.sv
hw/rtl/bbie_if.sv
hw/rtl/bbie_store.sv
hw/rtl/byte_buffer_insert_erase_get.sv
tb/tb_byte_buffer_insert_erase_get.sv
